// ===== hw/rtl/pcap_pkg.sv =====
// Shared types, codes and helpers for the pcap stream parser.
package pcap_pkg;

    // Magic values, taken as little-endian words
    localparam logic [31:0] MAGIC_US_NATIVE  = 32'ha1b2c3d4;
    localparam logic [31:0] MAGIC_US_SWAPPED = 32'hd4c3b2a1;
    localparam logic [31:0] MAGIC_NS_NATIVE  = 32'ha1b23c4d;
    localparam logic [31:0] MAGIC_NS_SWAPPED = 32'h4d3cb2a1;
    localparam logic [31:0] MAGIC_NS_OTHER   = 32'ha3b4c3d4;
    localparam logic [31:0] MAGIC_PCAPNG     = 32'h0a0d0d0a;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [9:0]  NS_PER_US  = 10'd1000;

    // Register reset values
    localparam logic [15:0] CAPTURE_LIMIT_RST = 16'hffff;
    localparam logic [31:0] SANITY_LIMIT_RST  = 32'h0100_0000;
    localparam logic [31:0] LINK_TYPE_RST     = 32'd1;

    // Configuration register indexes
    localparam int unsigned  CFG_IDX_W       = 2;
    localparam logic [1:0]   CFG_CAPTURE     = 2'd0;
    localparam logic [1:0]   CFG_SANITY      = 2'd1;
    localparam logic [1:0]   CFG_LINK        = 2'd2;

    // Parser phases
    localparam logic [2:0] PH_FILE_HDR = 3'd0;
    localparam logic [2:0] PH_REC_HDR  = 3'd1;
    localparam logic [2:0] PH_DATA     = 3'd2;
    localparam logic [2:0] PH_SKIP     = 3'd3;
    localparam logic [2:0] PH_STOPPED  = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_DESC    = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Summary status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
    localparam logic [2:0] ST_PCAPNG     = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd3;
    localparam logic [2:0] ST_LINK       = 3'd4;
    localparam logic [2:0] ST_LENGTH     = 3'd5;
    localparam logic [2:0] ST_SHORT_DATA = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        end_of_packet;
        logic [62:0] timestamp_ns;
        logic [31:0] wire_len;
        logic [15:0] pass_len;
        logic        truncated;
        logic [2:0]  status;
        logic [31:0] rec_total;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result res;
    } t_core_out;

    function automatic logic [31:0] byte_rev(input logic [31:0] v);
        byte_rev = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ===== hw/rtl/pcap_if.sv =====
// Input and output channel interfaces of the pcap stream parser.
interface pcap_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_byte;

    modport source (output valid, output func, output in_byte, input ready);
    modport sink (input valid, input func, input in_byte, output ready);
endinterface

interface pcap_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        end_of_packet;
    logic [62:0] timestamp_ns;
    logic [31:0] wire_len;
    logic [15:0] pass_len;
    logic        truncated;
    logic [2:0]  status;
    logic [31:0] rec_total;

    modport source (
        output valid, output kind, output data_byte, output end_of_packet,
        output timestamp_ns, output wire_len, output pass_len,
        output truncated, output status, output rec_total, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input end_of_packet,
        input timestamp_ns, input wire_len, input pass_len,
        input truncated, input status, input rec_total, output ready
    );
endinterface

// ===== hw/rtl/pcap_core.sv =====
// Parser state machine, configuration registers and result formation.
module pcap_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic                 i_func,
    input  logic [7:0]           i_byte,
    input  logic                 i_cfg_we,
    input  logic [pcap_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    output pcap_pkg::t_core_out  o_co
);

    // Configuration registers
    logic [15:0] r_cap;
    logic [31:0] r_san;
    logic [31:0] r_link;

    // Control state
    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_idx, n_idx;
    logic        r_swap, n_swap;
    logic        r_ns, n_ns;
    logic [15:0] r_copy, n_copy;
    logic [31:0] r_done, n_done;
    logic [2:0]  r_stat, n_stat;

    // Header assembly
    logic [31:0] r_wa, n_wa;
    logic [31:0] r_wb, n_wb;
    logic [31:0] r_wc, n_wc;
    logic [31:0] r_incl, n_incl;

    // Timestamp partial products
    logic [61:0] r_sec_ns;
    logic [41:0] r_frac_ns;

    logic [31:0] w_nidx;
    logic [31:0] w_sec_o;
    logic [31:0] w_frac_o;
    logic [31:0] w_incl_o;
    logic [31:0] w_orig_o;
    logic [31:0] w_shift_b;
    logic [31:0] w_shift_c;
    logic [31:0] w_link_o;
    logic [31:0] w_done_inc;
    logic        w_trunc;
    logic [15:0] w_copy;
    logic        w_last;
    pcap_pkg::t_core_out w_co;

    assign w_nidx    = r_idx + 32'd1;
    assign w_shift_b = {i_byte, r_wb[31:8]};
    assign w_shift_c = {i_byte, r_wc[31:8]};
    assign w_sec_o   = r_swap ? pcap_pkg::byte_rev(r_wa) : r_wa;
    assign w_frac_o  = r_swap ? pcap_pkg::byte_rev(r_wb) : r_wb;
    assign w_incl_o  = r_swap ? pcap_pkg::byte_rev(r_incl) : r_incl;
    assign w_orig_o  = r_swap ? pcap_pkg::byte_rev(w_shift_c) : w_shift_c;
    assign w_done_inc = (r_done == 32'hffff_ffff) ? r_done : r_done + 32'd1;
    assign w_trunc   = w_incl_o > {16'd0, r_cap};
    assign w_copy    = w_trunc ? r_cap : w_incl_o[15:0];
    assign w_last    = w_nidx >= {16'd0, r_copy};

    // Order the link type by the byte order that the magic selects
    always_comb begin
        if (r_wa == pcap_pkg::MAGIC_US_SWAPPED || r_wa == pcap_pkg::MAGIC_NS_SWAPPED) begin
            w_link_o = pcap_pkg::byte_rev(w_shift_b);
        end else begin
            w_link_o = w_shift_b;
        end
    end

    // Step the parser for one accepted item
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_swap  = r_swap;
        n_ns    = r_ns;
        n_copy  = r_copy;
        n_done  = r_done;
        n_stat  = r_stat;
        n_wa    = r_wa;
        n_wb    = r_wb;
        n_wc    = r_wc;
        n_incl  = r_incl;
        w_co    = '0;
        if (i_acc && i_func) begin
            // End of stream: settle the status and report the summary
            case (r_phase)
                pcap_pkg::PH_FILE_HDR: n_stat = pcap_pkg::ST_SHORT_HDR;
                pcap_pkg::PH_DATA:     n_stat = pcap_pkg::ST_SHORT_DATA;
                pcap_pkg::PH_REC_HDR,
                pcap_pkg::PH_SKIP:     n_stat = pcap_pkg::ST_OK;
                default:               n_stat = r_stat;
            endcase
            n_phase = pcap_pkg::PH_STOPPED;
            w_co.push = 1'b1;
            w_co.res.kind = pcap_pkg::KIND_SUMMARY;
            w_co.res.status = n_stat;
            w_co.res.rec_total = r_done;
        end else if (i_acc) begin
            case (r_phase)
                pcap_pkg::PH_FILE_HDR: begin
                    if (r_idx < 32'd4) begin
                        n_wa = {i_byte, r_wa[31:8]};
                    end else if (r_idx >= 32'd20) begin
                        n_wb = w_shift_b;
                    end
                    n_idx = w_nidx;
                    // Check magic and link type on the last header byte
                    if (r_idx == 32'd23) begin
                        n_phase = pcap_pkg::PH_REC_HDR;
                        n_idx = '0;
                        if (r_wa == pcap_pkg::MAGIC_PCAPNG) begin
                            n_phase = pcap_pkg::PH_STOPPED;
                            n_stat = pcap_pkg::ST_PCAPNG;
                        end else if (r_wa == pcap_pkg::MAGIC_US_NATIVE) begin
                            n_swap = 1'b0;
                            n_ns = 1'b0;
                        end else if (r_wa == pcap_pkg::MAGIC_US_SWAPPED) begin
                            n_swap = 1'b1;
                            n_ns = 1'b0;
                        end else if (r_wa == pcap_pkg::MAGIC_NS_NATIVE ||
                                     r_wa == pcap_pkg::MAGIC_NS_OTHER) begin
                            n_swap = 1'b0;
                            n_ns = 1'b1;
                        end else if (r_wa == pcap_pkg::MAGIC_NS_SWAPPED) begin
                            n_swap = 1'b1;
                            n_ns = 1'b1;
                        end else begin
                            n_phase = pcap_pkg::PH_STOPPED;
                            n_stat = pcap_pkg::ST_BAD_MAGIC;
                        end
                        if (n_phase == pcap_pkg::PH_REC_HDR && w_link_o != r_link) begin
                            n_phase = pcap_pkg::PH_STOPPED;
                            n_stat = pcap_pkg::ST_LINK;
                        end
                    end
                end
                pcap_pkg::PH_REC_HDR: begin
                    if (r_idx < 32'd4) begin
                        n_wa = {i_byte, r_wa[31:8]};
                    end else if (r_idx < 32'd8) begin
                        n_wb = w_shift_b;
                    end else if (r_idx < 32'd12) begin
                        n_incl = {i_byte, r_incl[31:8]};
                    end else begin
                        n_wc = w_shift_c;
                    end
                    n_idx = w_nidx;
                    // Record header complete: check length, emit descriptor
                    if (r_idx == 32'd15) begin
                        n_incl = w_incl_o;
                        n_idx = '0;
                        if (w_incl_o > r_san) begin
                            n_phase = pcap_pkg::PH_STOPPED;
                            n_stat = pcap_pkg::ST_LENGTH;
                        end else begin
                            n_copy = w_copy;
                            w_co.push = 1'b1;
                            w_co.res.kind = pcap_pkg::KIND_DESC;
                            w_co.res.timestamp_ns = 63'(r_sec_ns) + 63'(r_frac_ns);
                            w_co.res.wire_len = w_orig_o;
                            w_co.res.pass_len = w_copy;
                            w_co.res.truncated = w_trunc;
                            if (w_copy == 16'd0) begin
                                n_done = w_done_inc;
                                n_phase = (w_incl_o != 32'd0) ? pcap_pkg::PH_SKIP
                                                              : pcap_pkg::PH_REC_HDR;
                            end else begin
                                n_phase = pcap_pkg::PH_DATA;
                            end
                        end
                    end
                end
                pcap_pkg::PH_DATA: begin
                    n_idx = w_nidx;
                    w_co.push = 1'b1;
                    w_co.res.kind = pcap_pkg::KIND_DATA;
                    w_co.res.data_byte = i_byte;
                    w_co.res.end_of_packet = w_last;
                    if (w_last) begin
                        n_done = w_done_inc;
                        if (r_incl > w_nidx) begin
                            n_phase = pcap_pkg::PH_SKIP;
                        end else begin
                            n_phase = pcap_pkg::PH_REC_HDR;
                            n_idx = '0;
                        end
                    end
                end
                pcap_pkg::PH_SKIP: begin
                    n_idx = w_nidx;
                    if (w_nidx >= r_incl) begin
                        n_phase = pcap_pkg::PH_REC_HDR;
                        n_idx = '0;
                    end
                end
                default: begin
                    n_phase = pcap_pkg::PH_STOPPED;
                end
            endcase
        end
    end

    assign o_co = w_co;

    // Hold control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcap_pkg::PH_FILE_HDR;
            r_idx   <= '0;
            r_swap  <= 1'b0;
            r_ns    <= 1'b0;
            r_copy  <= '0;
            r_done  <= '0;
            r_stat  <= pcap_pkg::ST_OK;
            r_cap   <= pcap_pkg::CAPTURE_LIMIT_RST;
            r_san   <= pcap_pkg::SANITY_LIMIT_RST;
            r_link  <= pcap_pkg::LINK_TYPE_RST;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_swap  <= n_swap;
            r_ns    <= n_ns;
            r_copy  <= n_copy;
            r_done  <= n_done;
            r_stat  <= n_stat;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcap_pkg::CFG_CAPTURE: r_cap  <= i_cfg_data[15:0];
                    pcap_pkg::CFG_SANITY:  r_san  <= i_cfg_data;
                    pcap_pkg::CFG_LINK:    r_link <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Assemble header words; seconds and fraction settle long before the
    // last record header byte, so their scaled values are registered here
    always_ff @(posedge i_clk) begin
        r_wa   <= n_wa;
        r_wb   <= n_wb;
        r_wc   <= n_wc;
        r_incl <= n_incl;
        r_sec_ns <= 62'(w_sec_o) * 62'(pcap_pkg::NS_PER_SEC);
        if (r_ns) begin
            r_frac_ns <= 42'(w_frac_o);
        end else begin
            r_frac_ns <= 42'(w_frac_o) * 42'(pcap_pkg::NS_PER_US);
        end
    end

    a_eos_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_func) |-> (o_co.push && o_co.res.kind == pcap_pkg::KIND_SUMMARY))
        else $error("end of stream without summary");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pcap_pkg::PH_STOPPED) |=> (r_phase == pcap_pkg::PH_STOPPED))
        else $error("parser left the stopped phase");

    a_desc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_co.push && o_co.res.kind == pcap_pkg::KIND_DESC)
            |-> (o_co.res.pass_len <= r_cap))
        else $error("descriptor length above capture limit");

endmodule

// ===== hw/rtl/pcap_ofifo.sv =====
// Two-entry result queue between the parser and the output channel.
module pcap_ofifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcap_pkg::t_result i_data,
    input  logic              i_pop,
    output pcap_pkg::t_result o_data,
    output logic              o_valid,
    output logic              o_full
);

    pcap_pkg::t_result r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Store an item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2))
        else $error("push into full result queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty result queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

endmodule

// ===== hw/rtl/pcap_stream_parser.sv =====
// Classic pcap stream parser top level.
// Usage:
//   i_in carries one file byte per item (func 0) or an end-of-stream item
//   (func 1). o_out carries record descriptors, passed data bytes and the
//   final summary. The configuration write port sets capture limit, sanity
//   limit and required link type; write it only while the block is idle.
// Results: an accepted item's result, if any, is registered into the
//   two-entry result queue at the edge that accepts the item.
// Throughput: one input item per cycle while the result queue is not
//   full; each item is handled in the cycle it is accepted.
// Stall: while o_out is stalled the queue absorbs results; i_in.ready drops
//   only when both queue entries hold results not yet taken.
// Reset: configuration returns to its defaults (capture 65535, sanity
//   16777216, link type 1), the queue empties, and the parser expects a
//   file header. No clearing pass is needed; items are taken at once.
// After an error or end of stream, bytes are ignored and each further
//   end-of-stream item repeats the summary.
module pcap_stream_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pcap_in_if.sink                          i_in,
    pcap_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [pcap_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                      i_cfg_data
);

    pcap_pkg::t_core_out w_co;
    pcap_pkg::t_result   w_res;
    logic                w_full;
    logic                w_valid;
    logic                w_acc;
    logic                w_pop;

    assign i_in.ready = ~w_full;
    assign w_acc = i_in.valid & ~w_full;
    assign w_pop = w_valid & o_out.ready;

    pcap_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (w_acc),
        .i_func     (i_in.func),
        .i_byte     (i_in.in_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_co       (w_co)
    );

    pcap_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_co.push),
        .i_data  (w_co.res),
        .i_pop   (w_pop),
        .o_data  (w_res),
        .o_valid (w_valid),
        .o_full  (w_full)
    );

    // Drive the output channel from the queue head
    assign o_out.valid         = w_valid;
    assign o_out.kind          = w_res.kind;
    assign o_out.data_byte     = w_res.data_byte;
    assign o_out.end_of_packet = w_res.end_of_packet;
    assign o_out.timestamp_ns  = w_res.timestamp_ns;
    assign o_out.wire_len      = w_res.wire_len;
    assign o_out.pass_len      = w_res.pass_len;
    assign o_out.truncated     = w_res.truncated;
    assign o_out.status        = w_res.status;
    assign o_out.rec_total     = w_res.rec_total;

endmodule
